// File: hw/rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared sizes and types of the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

    // Ring depth, a power of two.
    localparam int DEPTH     = 1024;
    // Largest get burst.
    localparam int MAX_BURST = 64;

    localparam int ADDR_W    = $clog2(DEPTH);
    // Free-running indices carry one wrap bit above the address.
    localparam int IDX_W     = ADDR_W + 1;
    localparam int BURST_W   = $clog2(MAX_BURST + 1);
    localparam int REQ_W     = 7;
    localparam int CNT_W     = 11;
    localparam int CMP_W     = (IDX_W > REQ_W) ? IDX_W : REQ_W;

    typedef logic [7:0]         t_byte;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [BURST_W-1:0] t_burst;
    typedef logic [REQ_W-1:0]   t_req;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [CMP_W-1:0]   t_cmp;

    localparam t_cnt COUNT_MAX  = '1;

    // Operation codes.
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

endpackage

// File: hw/rtl/byte_ring_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte FIFO in a power-of-two ring memory with free-running indices.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  command  | start / busy          | i_operation, i_data_byte, i_burst_end,
//           |                       | i_request_length
//  result   | o_valid (one cycle)   | o_out_byte, o_byte_valid, o_accepted,
//           |                       | o_running_count, o_last
//
//  A command transfers on a clock edge with start high and busy low.
//  A put's result shows in the next cycle and busy stays low, so puts stream
//  one byte per cycle. A get of n bytes (n = min(request, MAX_BURST, fill
//  level)) makes one memory read per cycle through the single read port;
//  bytes show from the cycle after the transfer on, and busy is high while
//  the reads after the first are issued. An empty or zero-length get gives
//  a single result with a zero count and leaves busy low.
//  Reset (i_rst_n low, synchronous) empties the FIFO; no clearing pass is run.
//  The receiver takes every result as it comes and cannot stall the block.
//
module byte_ring_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  brf_pkg::t_byte        i_data_byte,
    input  logic                  i_burst_end,
    input  brf_pkg::t_req         i_request_length,

    output logic                  o_valid,
    output brf_pkg::t_byte        o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_accepted,
    output brf_pkg::t_cnt         o_running_count,
    output logic                  o_last
);

    // ring memory and its registered read port
    brf_pkg::t_byte  mem [brf_pkg::DEPTH];
    brf_pkg::t_byte  r_rd_data;

    // indices and burst bookkeeping
    brf_pkg::t_idx   r_write_index, n_write_index;
    brf_pkg::t_idx   r_read_index,  n_read_index;
    brf_pkg::t_cnt   r_put_cnt,     n_put_cnt;
    brf_pkg::t_burst r_remain,      n_remain;   // reads still to issue

    // result registers
    logic            r_res_valid,    n_res_valid;
    logic            r_res_is_byte,  n_res_is_byte;
    logic            r_res_accepted, n_res_accepted;
    brf_pkg::t_cnt   r_res_count,    n_res_count;
    logic            r_res_last,     n_res_last;

    logic            cmd_xfer;
    brf_pkg::t_idx   fill;
    logic            full;
    brf_pkg::t_req   req_clamp;
    brf_pkg::t_burst get_len;
    brf_pkg::t_cnt   put_cnt_inc;
    logic            mem_we;
    logic            rd_en;

    assign busy     = (r_remain != '0);
    assign cmd_xfer = start && !busy;

    // fill never exceeds DEPTH, so the wrap bit alone flags full
    assign fill = brf_pkg::t_idx'(r_write_index - r_read_index);
    assign full = fill[brf_pkg::ADDR_W];

    assign req_clamp = (i_request_length > brf_pkg::t_req'(brf_pkg::MAX_BURST))
                     ? brf_pkg::t_req'(brf_pkg::MAX_BURST) : i_request_length;

    // a fill below the request is below MAX_BURST and fits the burst width
    assign get_len = (brf_pkg::t_cmp'(fill) < brf_pkg::t_cmp'(req_clamp))
                   ? brf_pkg::t_burst'(brf_pkg::t_cmp'(fill))
                   : brf_pkg::t_burst'(req_clamp);

    assign put_cnt_inc = (r_put_cnt != brf_pkg::COUNT_MAX)
                       ? brf_pkg::t_cnt'(r_put_cnt + 1'b1) : r_put_cnt;

    always_comb begin
        n_write_index  = r_write_index;
        n_read_index   = r_read_index;
        n_put_cnt      = r_put_cnt;
        n_remain       = r_remain;
        n_res_valid    = 1'b0;
        n_res_is_byte  = 1'b0;
        n_res_accepted = 1'b0;
        n_res_count    = r_res_count;
        n_res_last     = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;

        if (busy) begin
            // continue a get burst: one read per cycle
            rd_en         = 1'b1;
            n_read_index  = brf_pkg::t_idx'(r_read_index + 1'b1);
            n_remain      = brf_pkg::t_burst'(r_remain - 1'b1);
            n_res_valid   = 1'b1;
            n_res_is_byte = 1'b1;
            n_res_count   = brf_pkg::t_cnt'(r_res_count + 1'b1);
            n_res_last    = (r_remain == brf_pkg::t_burst'(1));
        end else if (cmd_xfer) begin
            n_res_valid = 1'b1;
            n_res_last  = 1'b1;
            case (i_operation)
                brf_pkg::OP_PUT: begin
                    n_res_count = r_put_cnt;
                    if (!full) begin
                        mem_we         = 1'b1;
                        n_write_index  = brf_pkg::t_idx'(r_write_index + 1'b1);
                        n_res_accepted = 1'b1;
                        n_res_count    = put_cnt_inc;
                        n_put_cnt      = put_cnt_inc;
                    end
                    // burst end clears the count whether or not stored
                    if (i_burst_end) begin
                        n_put_cnt = '0;
                    end
                end
                brf_pkg::OP_GET: begin
                    if (get_len == '0) begin
                        n_res_count = '0;
                    end else begin
                        rd_en         = 1'b1;
                        n_read_index  = brf_pkg::t_idx'(r_read_index + 1'b1);
                        n_remain      = brf_pkg::t_burst'(get_len - 1'b1);
                        n_res_is_byte = 1'b1;
                        n_res_count   = brf_pkg::t_cnt'(1);
                        n_res_last    = (get_len == brf_pkg::t_burst'(1));
                    end
                end
                default: begin
                    n_res_valid = 1'b0;
                end
            endcase
        end
    end

    // Reads and writes never hit one entry in the same cycle: only one
    // command moves per cycle, and a get reads only entries written on an
    // earlier edge, so no forwarding path is needed.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_write_index[brf_pkg::ADDR_W-1:0]] <= i_data_byte;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_read_index[brf_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index <= '0;
            r_read_index  <= '0;
            r_put_cnt     <= '0;
            r_remain      <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            r_write_index <= n_write_index;
            r_read_index  <= n_read_index;
            r_put_cnt     <= n_put_cnt;
            r_remain      <= n_remain;
            r_res_valid   <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_is_byte  <= n_res_is_byte;
        r_res_accepted <= n_res_accepted;
        r_res_count    <= n_res_count;
        r_res_last     <= n_res_last;
    end

    assign o_valid         = r_res_valid;
    assign o_out_byte      = r_res_is_byte ? r_rd_data : '0;
    assign o_byte_valid    = r_res_is_byte;
    assign o_accepted      = r_res_accepted;
    assign o_running_count = r_res_count;
    assign o_last          = r_res_last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= brf_pkg::t_idx'(brf_pkg::DEPTH))
        else $error("fill level above depth");

    a_busy_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid && o_byte_valid)
        else $error("burst read without a result");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid && !o_last |=> o_valid && o_byte_valid)
        else $error("get burst broke off early");

    a_no_put_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_write_index))
        else $error("write index moved during a get burst");
`endif

endmodule
